FILE: rtl/pencil_sketch_pixel_defines.svh
// Assertion macros shared by the pencil sketch checker.
`ifndef PENCIL_SKETCH_PIXEL_DEFINES_SVH
`define PENCIL_SKETCH_PIXEL_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PSPX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define PSPX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define PSPX_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pspx_pkg.sv
// Types and constants of the pencil sketch pixel filter.
`default_nettype none

package pspx_pkg;

  localparam int PIX_W   = 8;
  localparam int MODE_W  = 4;
  localparam int SQ_W    = 16;
  localparam int PROD_W  = 24;
  localparam int CFG_IDX_W = 2;

  // Blend selection codes
  localparam logic [MODE_W-1:0] MODE_DNEG    = 4'd0;
  localparam logic [MODE_W-1:0] MODE_MIN     = 4'd1;
  localparam logic [MODE_W-1:0] MODE_MAX     = 4'd2;
  localparam logic [MODE_W-1:0] MODE_LIGHTEN = 4'd3;
  localparam logic [MODE_W-1:0] MODE_PQ      = 4'd5;
  localparam logic [MODE_W-1:0] MODE_DNEG2   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_COLOR   = 4'd7;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TMIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TMAX = 2'd2;

  localparam logic [PIX_W-1:0] MODE_RESET   = 8'd0;
  localparam logic [PIX_W-1:0] TMIN_RESET   = 8'd16;
  localparam logic [PIX_W-1:0] TMAX_RESET   = 8'd235;
  localparam logic [PIX_W-1:0] PIX_MAX      = 8'd255;
  localparam logic [PIX_W-1:0] LUMA_OUTSIDE = 8'd240;
  localparam logic [PIX_W-1:0] CHROMA_GRAY  = 8'd128;
  localparam logic [PIX_W-1:0] LIMIT_LO     = 8'd16;
  localparam logic [PIX_W-1:0] LIMIT_HI     = 8'd240;
  localparam logic [PIX_W-1:0] PQ_FILL      = 8'd16;

  // Front end result handed to the divider section
  typedef struct packed {
    logic [PIX_W-1:0] early;   // result of every path that needs no divide
    logic             use_div; // sketch pixel in max or pq blend
    logic             zero2;   // max blend with zero divisor
    logic [PIX_W-1:0] am;      // pq operand a with zero replaced
    logic [SQ_W-1:0]  n1;
    logic [PIX_W-1:0] d1;
    logic [SQ_W-1:0]  n2;
    logic [PIX_W-1:0] d2;
  } front_t;

endpackage

`default_nettype wire

FILE: rtl/pspx_pipe.sv
// Delay line with stall enable for valid bits and sideband data.
`default_nettype none

module pspx_pipe #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [DEPTH];

  // Shift one place per advance, clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) sr_r[i] <= '0;
    end else if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[DEPTH-1];

endmodule

`default_nettype wire

FILE: rtl/pspx_div.sv
// Pipelined restoring divider, STEP quotient bits per stage.
`default_nettype none

module pspx_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 8,
  parameter int STEP  = 2
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  localparam int STAGES = NUM_W / STEP;

  logic [DEN_W-1:0] rem_r [STAGES];
  logic [NUM_W-1:0] nq_r  [STAGES];
  logic [DEN_W-1:0] den_r [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [DEN_W-1:0] rem_in, rem_nxt, den_in;
    logic [NUM_W-1:0] nq_in, nq_nxt;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
    end else begin : g_rest
      assign rem_in = rem_r[g-1];
      assign nq_in  = nq_r[g-1];
      assign den_in = den_r[g-1];
    end

    // Shift in numerator bits, subtract where the divisor fits
    always_comb begin
      logic [DEN_W:0] t;
      rem_nxt = rem_in;
      nq_nxt  = nq_in;
      t       = '0;
      for (int i = 0; i < STEP; i++) begin
        t      = {rem_nxt, nq_nxt[NUM_W-1]};
        nq_nxt = {nq_nxt[NUM_W-2:0], 1'b0};
        if (t >= {1'b0, den_in}) begin
          rem_nxt   = DEN_W'(t - {1'b0, den_in});
          nq_nxt[0] = 1'b1;
        end else begin
          rem_nxt = t[DEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt;
        nq_r[g]  <= nq_nxt;
        den_r[g] <= den_in;
      end
    end
  end

  assign quo = nq_r[STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/pspx_front.sv
// Front stages: sharpening, simple blends and divider operands.
`default_nettype none

module pspx_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic                          in_plane,
  input  logic [pspx_pkg::PIX_W-1:0]    in_pixel,
  input  logic [pspx_pkg::PIX_W-1:0]    in_right_pixel,
  input  logic [pspx_pkg::PIX_W-1:0]    in_below_pixel,
  input  logic [pspx_pkg::PIX_W-1:0]    in_below_right_pixel,
  input  logic                          in_pass_through,
  input  logic [pspx_pkg::MODE_W-1:0]   mode,
  input  logic [pspx_pkg::PIX_W-1:0]    tmin,
  input  logic [pspx_pkg::PIX_W-1:0]    tmax,
  output logic                          fr_valid,
  output pspx_pkg::front_t              fr_data
);

  localparam logic [1:0] KIND_CHROMA = 2'd0;
  localparam logic [1:0] KIND_PASS   = 2'd1;
  localparam logic [1:0] KIND_OUTR   = 2'd2;
  localparam logic [1:0] KIND_SKETCH = 2'd3;

  // 255 - |255 - 2v|
  function automatic logic [7:0] fold(input logic [7:0] v);
    logic signed [9:0] d;
    logic        [9:0] ad;
    d  = 10'sd255 - $signed({1'b0, v, 1'b0});
    ad = (d < 0) ? 10'(-d) : 10'(d);
    return pspx_pkg::PIX_MAX - ad[7:0];
  endfunction

  // Pick 16 or 240 against the upper threshold
  function automatic logic [7:0] limit(input logic [7:0] p, input logic [7:0] tm);
    return (p >= pspx_pkg::LIMIT_LO || p <= tm) ? pspx_pkg::LIMIT_LO : pspx_pkg::LIMIT_HI;
  endfunction

  // ---------------- stage 1: sharpen ----------------
  logic       s1_valid_r;
  logic [1:0] s1_kind_r;
  logic [7:0] s1_y_r, s1_a_r;

  logic [9:0]         nb_sum;
  logic [7:0]         nb_mean;
  logic [11:0]        nine_y;
  logic signed [12:0] sharp;

  always_comb begin
    nb_sum  = {2'b0, in_right_pixel} + {2'b0, in_below_pixel} +
              {2'b0, in_below_right_pixel} + 10'd2;
    nb_mean = nb_sum[9:2];
    nine_y  = {1'b0, in_pixel, 3'b0} + {4'b0, in_pixel};
    // both halvings fold into one floor of (9y - 4m - 255) / 4
    sharp   = $signed({1'b0, nine_y}) - $signed({3'b0, nb_mean, 2'b0}) - 13'sd255;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_y_r <= in_pixel;
      s1_a_r <= sharp[9:2];
      if (in_plane) s1_kind_r <= KIND_CHROMA;
      else if (in_pass_through) s1_kind_r <= KIND_PASS;
      else if (in_pixel >= tmin && in_pixel <= tmax) s1_kind_r <= KIND_SKETCH;
      else s1_kind_r <= KIND_OUTR;
    end
  end

  // ---------------- stage 2: dneg core and squares ----------------
  logic       s2_valid_r;
  logic [1:0] s2_kind_r;
  logic [7:0] s2_y_r, s2_a_r, s2_p_r, s2_am_r, s2_d1_r, s2_d2_r;
  logic [15:0] s2_n1_r, s2_n2_r;

  logic signed [8:0] fd;
  logic [8:0]  fd_abs;
  logic [7:0]  p_dneg, am, bm, x1, d1, sq1_b, sq2_b;
  logic        is_max;

  always_comb begin
    fd     = $signed({1'b0, fold(s1_a_r)}) - $signed({1'b0, fold(s1_y_r)});
    fd_abs = (fd < 0) ? 9'(-fd) : 9'(fd);
    p_dneg = pspx_pkg::PIX_MAX - fd_abs[7:0];
    am     = (s1_a_r == 8'd0) ? pspx_pkg::PQ_FILL : s1_a_r;
    bm     = (s1_y_r == 8'd0) ? pspx_pkg::PQ_FILL : s1_y_r;
    is_max = (mode == pspx_pkg::MODE_MAX);
    x1     = is_max ? s1_y_r : am;
    d1     = is_max ? ((s1_a_r > s1_y_r) ? s1_a_r : s1_y_r) : am;
    sq1_b  = pspx_pkg::PIX_MAX - x1;
    sq2_b  = pspx_pkg::PIX_MAX - bm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind_r <= s1_kind_r;
      s2_y_r    <= s1_y_r;
      s2_a_r    <= s1_a_r;
      s2_p_r    <= p_dneg;
      s2_am_r   <= am;
      s2_d1_r   <= d1;
      s2_d2_r   <= bm;
      s2_n1_r   <= sq1_b * sq1_b;
      s2_n2_r   <= sq2_b * sq2_b;
    end
  end

  // ---------------- stage 3: finish simple blends ----------------
  logic       s3_valid_r;
  pspx_pkg::front_t s3_r;

  logic [7:0]  t1, mn, mx, res, early, dn;
  logic signed [8:0] t2;
  logic [8:0]  t2_abs;
  logic signed [9:0] v1, v6;
  logic [9:0]  v1_abs, v6_abs;
  logic [15:0] prod7;
  logic        use_div;

  always_comb begin
    t1     = (s2_p_r > s2_y_r) ? (s2_p_r - s2_y_r) : (s2_y_r - s2_p_r);
    t2     = $signed({1'b0, t1}) - $signed({1'b0, s2_y_r});
    t2_abs = (t2 < 0) ? 9'(-t2) : 9'(t2);
    dn     = t2_abs[7:0];
    mn     = (s2_y_r < s2_a_r) ? s2_y_r : s2_a_r;
    mx     = (s2_a_r > s2_y_r) ? s2_a_r : s2_y_r;
    v1     = 10'sd255 - $signed({2'b0, mn}) - $signed({2'b0, s2_y_r});
    v1_abs = (v1 < 0) ? 10'(-v1) : 10'(v1);
    v6     = 10'sd255 - $signed({2'b0, s2_a_r}) - $signed({2'b0, s2_y_r});
    v6_abs = (v6 < 0) ? 10'(-v6) : 10'(v6);
    prod7  = dn * s2_y_r;
    use_div = 1'b0;
    case (mode)
      pspx_pkg::MODE_DNEG:    res = dn;
      pspx_pkg::MODE_MIN:     res = pspx_pkg::PIX_MAX - v1_abs[7:0];
      pspx_pkg::MODE_MAX:     begin res = '0; use_div = 1'b1; end
      pspx_pkg::MODE_LIGHTEN: res = mx;
      pspx_pkg::MODE_PQ:      begin res = '0; use_div = 1'b1; end
      pspx_pkg::MODE_DNEG2:   res = limit(pspx_pkg::PIX_MAX - v6_abs[7:0], tmax);
      pspx_pkg::MODE_COLOR:   res = dn + s2_y_r - prod7[15:8];
      default:                res = limit(s2_a_r, tmax);
    endcase
    case (s2_kind_r)
      KIND_CHROMA: begin
        early   = (mode == pspx_pkg::MODE_COLOR) ? s2_y_r : pspx_pkg::CHROMA_GRAY;
        use_div = 1'b0;
      end
      KIND_PASS:   begin early = s2_y_r; use_div = 1'b0; end
      KIND_OUTR:   begin early = pspx_pkg::LUMA_OUTSIDE; use_div = 1'b0; end
      default:     early = res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r.early   <= early;
      s3_r.use_div <= use_div;
      s3_r.zero2   <= (s2_d1_r == 8'd0);
      s3_r.am      <= s2_am_r;
      s3_r.n1      <= s2_n1_r;
      s3_r.d1      <= s2_d1_r;
      s3_r.n2      <= s2_n2_r;
      s3_r.d2      <= s2_d2_r;
    end
  end

  assign fr_valid = s3_valid_r;
  assign fr_data  = s3_r;

endmodule

`default_nettype wire

FILE: rtl/pencil_sketch_pixel.sv
// Top level of the pencil sketch pixel filter.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+-------------------------------------------
//  input   | in_valid  | in_ready  | plane, pixel, three neighbours, pass flag
//  result  | out_valid | out_ready | pixel_out
//  config  | cfg_valid | cfg_ready | cfg_index, cfg_data
//
// One pixel enters per clock unless a held result stalls the pipe. Results leave
// through the two chained divider pipelines of the pq blend and the output register.
// A stalled output freezes every stage at once, so nothing is dropped or repeated.
// Reset is synchronous: it clears all valid bits and loads the register defaults.
// Configuration writes are taken in every cycle.
`default_nettype none

module pencil_sketch_pixel #(
  parameter int DIV_STEP = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_plane,
  input  logic [7:0]                        in_pixel,
  input  logic [7:0]                        in_right_pixel,
  input  logic [7:0]                        in_below_pixel,
  input  logic [7:0]                        in_below_right_pixel,
  input  logic                              in_pass_through,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_pixel_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pspx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                        cfg_data
);

  localparam int DIV1_LAT = pspx_pkg::SQ_W / DIV_STEP;
  localparam int DIV3_LAT = pspx_pkg::PROD_W / DIV_STEP;
  localparam int SIDE1_W  = 1 + 8 + 1 + 1 + 8;
  localparam int SIDE3_W  = 1 + 8 + 1;

  logic adv;

  // ---------------- configuration registers ----------------
  logic [pspx_pkg::MODE_W-1:0] mode_r;
  logic [7:0]                  tmin_r, tmax_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pspx_pkg::MODE_RESET[pspx_pkg::MODE_W-1:0];
      tmin_r <= pspx_pkg::TMIN_RESET;
      tmax_r <= pspx_pkg::TMAX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        pspx_pkg::REG_MODE: mode_r <= cfg_data[pspx_pkg::MODE_W-1:0];
        pspx_pkg::REG_TMIN: tmin_r <= cfg_data;
        pspx_pkg::REG_TMAX: tmax_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole pipe advances unless a finished result is held
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------- front stages ----------------
  logic             fr_valid;
  pspx_pkg::front_t fr;

  pspx_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .en                  (adv),
    .in_valid            (in_valid),
    .in_plane            (in_plane),
    .in_pixel            (in_pixel),
    .in_right_pixel      (in_right_pixel),
    .in_below_pixel      (in_below_pixel),
    .in_below_right_pixel(in_below_right_pixel),
    .in_pass_through     (in_pass_through),
    .mode                (mode_r),
    .tmin                (tmin_r),
    .tmax                (tmax_r),
    .fr_valid            (fr_valid),
    .fr_data             (fr)
  );

  // ---------------- first divides: max blend and both pq ratios ----------------
  logic [pspx_pkg::SQ_W-1:0] q1, q2;
  logic [SIDE1_W-1:0]        side1;

  pspx_div #(.NUM_W(pspx_pkg::SQ_W), .DEN_W(8), .STEP(DIV_STEP)) u_div1 (
    .clk(clk), .en(adv), .num(fr.n1), .den(fr.d1), .quo(q1)
  );

  pspx_div #(.NUM_W(pspx_pkg::SQ_W), .DEN_W(8), .STEP(DIV_STEP)) u_div2 (
    .clk(clk), .en(adv), .num(fr.n2), .den(fr.d2), .quo(q2)
  );

  pspx_pipe #(.W(SIDE1_W), .DEPTH(DIV1_LAT)) u_side1 (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .d({fr_valid, fr.early, fr.use_div, fr.zero2, fr.am}),
    .q(side1)
  );

  // ---------------- middle stage: max result and pq operands ----------------
  logic                        d1_valid, d1_use, d1_zero;
  logic [7:0]                  d1_early, d1_am;
  logic                        md_valid_r, md_pq_r;
  logic [7:0]                  md_early_r, md_den_r;
  logic [pspx_pkg::PROD_W-1:0] md_num_r;

  assign {d1_valid, d1_early, d1_use, d1_zero, d1_am} = side1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_valid_r <= 1'b0;
    end else if (adv) begin
      md_valid_r <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      md_pq_r  <= d1_use && (mode_r == pspx_pkg::MODE_PQ);
      if (d1_use && mode_r == pspx_pkg::MODE_MAX)
        md_early_r <= d1_zero ? 8'd0 : pspx_pkg::PIX_MAX - q1[7:0];
      else
        md_early_r <= d1_early;
      md_den_r <= (q2 < 16'd255) ? pspx_pkg::PIX_MAX - q2[7:0] : pspx_pkg::PQ_FILL;
      md_num_r <= q1 * (pspx_pkg::PIX_MAX - d1_am);
    end
  end

  // ---------------- final divide of the pq blend ----------------
  logic [pspx_pkg::PROD_W-1:0] q3;
  logic [SIDE3_W-1:0]          side3;
  logic                        f_valid, f_pq;
  logic [7:0]                  f_early;

  pspx_div #(.NUM_W(pspx_pkg::PROD_W), .DEN_W(8), .STEP(DIV_STEP)) u_div3 (
    .clk(clk), .en(adv), .num(md_num_r), .den(md_den_r), .quo(q3)
  );

  pspx_pipe #(.W(SIDE3_W), .DEPTH(DIV3_LAT)) u_side3 (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .d({md_valid_r, md_early_r, md_pq_r}),
    .q(side3)
  );

  assign {f_valid, f_early, f_pq} = side3;

  // ---------------- output register ----------------
  logic       out_valid_r;
  logic [7:0] out_pixel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel_r <= f_pq ? pspx_pkg::PIX_MAX - q3[7:0] : f_early;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;

endmodule

`default_nettype wire

FILE: rtl/pspx_checker.sv
// Port checker for the pencil sketch pixel filter and its bind.
`default_nettype none
`include "pencil_sketch_pixel_defines.svh"

module pspx_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_pixel_out
);

  // Hold a stalled result
  `PSPX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel_out), "stalled result changed")

  // Input side stalls exactly when a held result blocks the pipe
  `PSPX_ASSERT_NOW(a_ready_stall, 1'b1, in_ready == (!out_valid || out_ready), "in_ready does not follow output stall")

  // Drop every result on reset
  `PSPX_ASSERT_ALWAYS_NEXT(a_reset_empty, !rst_n, !out_valid, "result valid right after reset")

  // Accept input while a transfer drains the output
  `PSPX_ASSERT_NOW(a_drain_ready, out_valid && out_ready, in_ready, "input blocked during output transfer")

endmodule

bind pencil_sketch_pixel pspx_checker u_pspx_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_pixel_out(out_pixel_out)
);

`default_nettype wire

FILE: test/tb_pencil_sketch_pixel.sv
// Self-checking testbench for the pencil sketch pixel filter.
`timescale 1ns / 100ps

module tb_pencil_sketch_pixel;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_PIXELS = 163;
  localparam logic [pspx_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [3:0] mode;
    logic [7:0] tmin;
    logic [7:0] tmax;
    logic       plane;
    logic [7:0] pix;
    logic [7:0] rgt;
    logic [7:0] blw;
    logic [7:0] blr;
    logic       pass;
    int         typed;   // -1: take the value from the predictor
  } sketch_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_plane;
  logic [7:0] in_pixel;
  logic [7:0] in_right_pixel;
  logic [7:0] in_below_pixel;
  logic [7:0] in_below_right_pixel;
  logic in_pass_through;
  logic out_valid;
  logic out_ready;
  logic [7:0] out_pixel_out;
  logic cfg_valid;
  logic cfg_ready;
  logic [pspx_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_data;

  // Predictor copy of the registers
  logic [3:0] pred_mode;
  logic [7:0] pred_tmin;
  logic [7:0] pred_tmax;

  logic [7:0] sketch_expected[$];
  sketch_row_t sketch_rows[$];
  int typed_value;
  int err_count;
  int cycle_count;
  int pixels_sent;
  int results_seen;
  int stall_left;
  bit no_idle;

  pencil_sketch_pixel dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_plane(in_plane), .in_pixel(in_pixel),
    .in_right_pixel(in_right_pixel), .in_below_pixel(in_below_pixel),
    .in_below_right_pixel(in_below_right_pixel),
    .in_pass_through(in_pass_through),
    .out_valid(out_valid), .out_ready(out_ready), .out_pixel_out(out_pixel_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int floor_half(int v);
    return (v >= 0) ? v / 2 : -((1 - v) / 2);
  endfunction

  function automatic int abs_int(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int limit_select(int p, logic [7:0] tmax);
    return (p >= 16 || p <= int'(tmax)) ? 16 : 240;
  endfunction

  function automatic int dodge_neg(int a, int b);
    int p;
    p = 255 - abs_int((255 - abs_int((255 - a) - a)) - (255 - abs_int((255 - b) - b)));
    p = p & 255;
    return abs_int(abs_int(p - b) - b) & 255;
  endfunction

  // Expected output value for one pixel under the current registers
  function automatic logic [7:0] sketch_predict(logic plane, logic [7:0] pix,
      logic [7:0] rgt, logic [7:0] blw, logic [7:0] blr, logic pass);
    int y, m, t, a, b, p, q, res;
    y = pix;
    if (plane) begin
      res = (pred_mode == pspx_pkg::MODE_COLOR) ? y : 128;
    end else if (pass) begin
      res = y;
    end else if (pix >= pred_tmin && pix <= pred_tmax) begin
      m = (int'(rgt) + int'(blw) + int'(blr) + 2) >>> 2;
      m = m + (y - m) * 5;
      t = floor_half(2 * y - (255 - m));
      t = floor_half(t + y);
      a = t & 255;
      b = y;
      case (pred_mode)
        pspx_pkg::MODE_DNEG: res = dodge_neg(a, b);
        pspx_pkg::MODE_MIN: begin
          p = (b < a) ? b : a;
          res = 255 - abs_int((255 - p) - b);
        end
        pspx_pkg::MODE_MAX: begin
          p = (b > a) ? b : a;
          if (p <= 0) res = 0;
          else res = 255 - ((255 - b) * (255 - b)) / p;
        end
        pspx_pkg::MODE_LIGHTEN: res = (a > b) ? a : b;
        pspx_pkg::MODE_PQ: begin
          if (a <= 0) a = 16;
          if (b <= 0) b = 16;
          p = 255 - ((255 - a) * (255 - a)) / a;
          q = 255 - ((255 - b) * (255 - b)) / b;
          if (q <= 0) q = 16;
          res = 255 - ((255 - p) * (255 - a)) / q;
        end
        pspx_pkg::MODE_DNEG2:
          res = limit_select((255 - abs_int((255 - a) - b)) & 255, pred_tmax);
        pspx_pkg::MODE_COLOR: begin
          p = dodge_neg(a, b);
          res = p + b - ((p * b) >>> 8);
        end
        default: res = limit_select(a, pred_tmax);
      endcase
    end else begin
      res = 240;
    end
    return res[7:0];
  endfunction

  // Sample all channels mid-cycle; transfers happen at the following edge
  always @(negedge clk) begin
    logic [7:0] want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pspx_pkg::REG_MODE: pred_mode = cfg_data[3:0];
          pspx_pkg::REG_TMIN: pred_tmin = cfg_data;
          pspx_pkg::REG_TMAX: pred_tmax = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = sketch_predict(in_plane, in_pixel, in_right_pixel, in_below_pixel,
                              in_below_right_pixel, in_pass_through);
        if (typed_value >= 0) want = typed_value[7:0];
        sketch_expected.push_back(want);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (sketch_expected.size() == 0) begin
          $display("%0t: unexpected result pixel_out=%0d", $time, out_pixel_out);
          err_count++;
        end else begin
          want = sketch_expected.pop_front();
          if (out_pixel_out !== want) begin
            $display("%0t: pixel_out mismatch expected=%0d actual=%0d",
                     $time, want, out_pixel_out);
            err_count++;
          end
        end
      end
    end
  end

  // Receiver stalls: mostly short, a few long, none while no_idle holds
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) < 7) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 3);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL pencil_sketch_pixel");
      $finish;
    end
  end

  task automatic write_reg(logic [pspx_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every expected pixel has come back, then let the pipe settle
  task automatic wait_drained();
    while (sketch_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(logic [3:0] mode, logic [7:0] tmin, logic [7:0] tmax);
    wait_drained();
    write_reg(pspx_pkg::REG_MODE, {4'($urandom_range(0, 15)), mode});
    write_reg(pspx_pkg::REG_TMIN, tmin);
    write_reg(pspx_pkg::REG_TMAX, tmax);
  endtask

  task automatic send_pixel(logic plane, logic [7:0] pix, logic [7:0] rgt,
      logic [7:0] blw, logic [7:0] blr, logic pass, int typed);
    int gap;
    bit taken;
    gap = no_idle ? 0 : (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    typed_value = typed;
    in_valid <= 1'b1;
    in_plane <= plane;
    in_pixel <= pix;
    in_right_pixel <= rgt;
    in_below_pixel <= blw;
    in_below_right_pixel <= blr;
    in_pass_through <= pass;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    pixels_sent++;
  endtask

  task automatic add_row(logic [3:0] mode, logic [7:0] tmin, logic [7:0] tmax,
      logic plane, logic [7:0] pix, logic [7:0] rgt, logic [7:0] blw,
      logic [7:0] blr, logic pass, int typed);
    sketch_rows.push_back('{mode, tmin, tmax, plane, pix, rgt, blw, blr, pass, typed});
  endtask

  initial begin
    sketch_row_t row;
    logic [3:0] cur_mode;
    logic [7:0] cur_tmin, cur_tmax, pix;
    logic plane;
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_plane = 1'b0;
    in_pixel = '0;
    in_right_pixel = '0;
    in_below_pixel = '0;
    in_below_right_pixel = '0;
    in_pass_through = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    typed_value = -1;
    err_count = 0;
    cycle_count = 0;
    pixels_sent = 0;
    results_seen = 0;
    no_idle = 1'b0;
    pred_mode = pspx_pkg::MODE_RESET[3:0];
    pred_tmin = pspx_pkg::TMIN_RESET;
    pred_tmax = pspx_pkg::TMAX_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: reset defaults, range edges, every blend mode
    add_row(0, 16, 235, 1, 200, 9, 9, 9, 0, 128);
    add_row(0, 16, 235, 1, 255, 255, 255, 255, 1, 128);
    add_row(0, 16, 235, 0, 0, 50, 60, 70, 1, 0);
    add_row(0, 16, 235, 0, 255, 0, 0, 0, 1, 255);
    add_row(0, 16, 235, 0, 0, 0, 0, 0, 0, 240);
    add_row(0, 16, 235, 0, 255, 255, 255, 255, 0, 240);
    add_row(0, 16, 235, 0, 16, 0, 0, 0, 0, -1);
    add_row(0, 16, 235, 0, 235, 255, 255, 255, 0, -1);
    add_row(0, 16, 235, 0, 100, 30, 200, 90, 0, -1);
    add_row(1, 16, 235, 0, 128, 20, 240, 60, 0, -1);
    add_row(2, 16, 235, 0, 40, 200, 10, 130, 0, -1);
    add_row(3, 16, 235, 0, 180, 100, 100, 100, 0, -1);
    add_row(4, 16, 235, 0, 90, 255, 0, 255, 0, -1);
    add_row(5, 16, 235, 0, 60, 70, 80, 90, 0, -1);
    add_row(6, 16, 235, 0, 200, 0, 255, 0, 0, -1);
    add_row(7, 16, 235, 0, 150, 140, 160, 170, 0, -1);
    add_row(7, 16, 235, 1, 77, 0, 0, 0, 0, 77);
    add_row(8, 16, 235, 0, 50, 10, 20, 30, 0, -1);
    add_row(15, 16, 235, 0, 220, 5, 250, 125, 0, -1);
    add_row(5, 0, 255, 0, 0, 0, 0, 0, 0, -1);
    add_row(2, 0, 255, 0, 0, 255, 255, 255, 0, -1);
    add_row(6, 0, 255, 0, 255, 0, 0, 0, 0, -1);
    add_row(5, 0, 255, 0, 255, 255, 255, 255, 0, -1);
    add_row(0, 255, 0, 0, 128, 1, 2, 3, 0, 240);

    cur_mode = pspx_pkg::MODE_RESET[3:0];
    cur_tmin = pspx_pkg::TMIN_RESET;
    cur_tmax = pspx_pkg::TMAX_RESET;
    foreach (sketch_rows[i]) begin
      row = sketch_rows[i];
      if (row.mode != cur_mode || row.tmin != cur_tmin || row.tmax != cur_tmax) begin
        in_valid <= 1'b0;
        @(posedge clk);
        load_config(row.mode, row.tmin, row.tmax);
        cur_mode = row.mode;
        cur_tmin = row.tmin;
        cur_tmax = row.tmax;
      end
      send_pixel(row.plane, row.pix, row.rgt, row.blw, row.blr, row.pass, row.typed);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    // The unused register index must leave everything unchanged
    wait_drained();
    write_reg(REG_UNUSED, 8'hA5);

    // Random phases, each under a fresh register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      cur_mode = (ph < 9) ? ph[3:0] : 4'($urandom_range(0, 15));
      case (ph % 4)
        0: begin cur_tmin = 0; cur_tmax = 255; end
        1: begin cur_tmin = 16; cur_tmax = 235; end
        default: begin
          cur_tmin = 8'($urandom_range(0, 255));
          cur_tmax = 8'($urandom_range(0, 255));
        end
      endcase
      in_valid <= 1'b0;
      @(posedge clk);
      load_config(cur_mode, cur_tmin, cur_tmax);
      no_idle = (ph % 5 == 3);
      n = PHASE_PIXELS;
      for (int k = 0; k < n; k++) begin
        plane = ($urandom_range(0, 3) == 0);
        pix = 8'($urandom_range(0, 255));
        // Steer most luma pixels into the sketched range
        if (!plane && cur_tmin <= cur_tmax && $urandom_range(0, 3) != 0)
          pix = 8'($urandom_range(cur_tmin, cur_tmax));
        send_pixel(plane, pix, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, -1);
      end
      no_idle = 1'b0;
    end
    in_valid <= 1'b0;
    @(posedge clk);

    wait_drained();
    $display("Sent %0d pixels across all blend modes and threshold settings,", pixels_sent);
    $display("checked %0d results with %0d mismatches.", results_seen, err_count);
    if (err_count == 0 && sketch_expected.size() == 0) begin
      $display("PASS pencil_sketch_pixel");
    end else begin
      $display("FAIL pencil_sketch_pixel");
    end
    $finish;
  end

endmodule
